>>> design/keyed_record_thinning_assert.svh
// ----------------------------------------------------------------------------
// keyed_record_thinning_assert.svh
// Assertion macros used by the thinning filter checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_THINNING_ASSERT_SVH
`define KEYED_RECORD_THINNING_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyed_record_thinning: assertion failed");

// Antecedent this cycle, consequent the next cycle.
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_record_thinning: assertion failed");

`endif

>>> design/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants of the per-key thinning filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package krt_pkg;

  localparam int unsigned KEY_W      = 4;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned TICK_SHIFT = 10;                 // 1024 ticks per second
  localparam int unsigned LEN_W      = CNT_W + TICK_SHIFT; // window length in ticks

  // Thinning modes
  localparam logic MODE_FREQUENCY = 1'b0;
  localparam logic MODE_TIME      = 1'b1;

  typedef enum logic [1:0] {
    CFG_THIN_MODE     = 2'd0,
    CFG_THIN_INTERVAL = 2'd1,
    CFG_WINDOW_ORIGIN = 2'd2
  } krt_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_FIN
  } krt_state_e;

endpackage

>>> design/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/krt_mod.sv
// ----------------------------------------------------------------------------
// krt_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_mod #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW:0]   trial;

  assign trial = {rem_q, quo_q[DW-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = VW'(trial - {1'b0, div_q});
      end else begin
        rem_d = VW'(trial);
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> design/keyed_record_thinning.sv
// ----------------------------------------------------------------------------
// keyed_record_thinning
// Per-key decimation filter: passes every Nth record of a key, or the first
// record of each time window of a key.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   record   | start_i, busy_o            | stream_key_i, sample_time_i
//   result   | result_valid_o (strobe)    | accepted_o
//   config   | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_wdata_i
//
// A record is taken when start_i is high and busy_o is low. Count-mode
// records, and time-mode records that need no remainder (dropped, or a zero
// interval), read their entry, then judge and write back. An accepted
// time-mode record with a nonzero interval also runs the remainder unit,
// which retires one dividend bit a cycle, before ST_FIN writes it back.
// The result strobe follows the last cycle; a new record may start in the
// same cycle the strobe shows. Reset clears the seen flags and registers at
// once; no clearing pass. The result has no back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_record_thinning
  import krt_pkg::*;
#(
  parameter int unsigned NUM_KEYS   = 16,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // record request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KEY_W-1:0]      stream_key_i,
  input  logic [TIME_WIDTH-1:0] sample_time_i,
  // result
  output logic                  result_valid_o,
  output logic                  accepted_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned ENTRY_W = CNT_W + TIME_WIDTH;
  localparam int unsigned SUM_W   = ((TIME_WIDTH > LEN_W) ? TIME_WIDTH : LEN_W) + 1;

  // Configuration registers
  logic                  mode_q;
  logic [CNT_W-1:0]      interval_q;
  logic [TIME_WIDTH-1:0] origin_q;

  // Control
  krt_state_e state_q, state_d;
  logic [NUM_KEYS-1:0] seen_q;
  logic                res_valid_q, res_valid_d;
  logic                res_acc_q, res_acc_d;

  // Per-record payload
  logic [KEY_W-1:0]      key_q;
  logic [AW-1:0]         addr_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic [CNT_W-1:0]      cnt_q;

  // Table port
  logic                  take;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  // Entry as seen by this record (fresh key gets zero count and the origin)
  logic                  key_ok;
  logic                  entry_seen;
  logic [CNT_W-1:0]      cur_cnt;
  logic [TIME_WIDTH-1:0] cur_win;
  logic                  cnt_hit;
  logic                  time_late;
  logic                  zero_len;
  logic                  go_div;
  logic [LEN_W-1:0]      win_len;

  // Window move
  logic                  mod_start;
  logic                  mod_done;
  logic [LEN_W-1:0]      mod_rem;
  logic [LEN_W-1:0]      adv;
  logic [SUM_W-1:0]      win_sum;
  logic [TIME_WIDTH-1:0] new_win;

  assign take        = start_i && !busy_o;
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_FREQUENCY;
      interval_q <= CNT_W'(1);
      origin_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_THIN_MODE:     mode_q     <= cfg_wdata_i[0];
        CFG_THIN_INTERVAL: interval_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_WINDOW_ORIGIN: origin_q   <= TIME_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Key table: {record count, next window start} per key
  // --------------------------------------------------------------------------
  krt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (AW'(stream_key_i)),
    .rdata_o (ram_rdata)
  );

  // Judge logic, valid in ST_LOOK once the read data is back
  assign key_ok     = (32'(key_q) < 32'(NUM_KEYS));
  assign entry_seen = seen_q[addr_q];
  assign cur_cnt    = entry_seen ? ram_rdata[ENTRY_W-1:TIME_WIDTH] : '0;
  assign cur_win    = entry_seen ? ram_rdata[TIME_WIDTH-1:0] : origin_q;
  assign cnt_hit    = (cur_cnt == (interval_q - CNT_W'(1)));
  assign time_late  = (time_q > cur_win);
  assign win_len    = {interval_q, {TICK_SHIFT{1'b0}}};
  assign zero_len   = (interval_q == '0);
  assign go_div     = key_ok && (mode_q == MODE_TIME) && time_late && !zero_len;

  // --------------------------------------------------------------------------
  // Remainder of (t - start) by the window length
  // --------------------------------------------------------------------------
  krt_mod #(
    .DW (TIME_WIDTH),
    .VW (LEN_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (time_q - cur_win),
    .divisor_i  (win_len),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // New start = t + (len - rem), held at the top of the time range
  assign adv     = win_len - mod_rem;
  assign win_sum = SUM_W'(time_q) + SUM_W'(adv);
  assign new_win = (win_sum > SUM_W'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                                                           : TIME_WIDTH'(win_sum);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take) state_d = ST_LOOK;
      ST_LOOK: state_d = go_div ? ST_DIV : ST_IDLE;
      ST_DIV:  if (mod_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    ram_we      = 1'b0;
    ram_wdata   = {cur_cnt, cur_win};
    mod_start   = 1'b0;
    res_valid_d = 1'b0;
    res_acc_d   = 1'b0;
    case (state_q)
      ST_LOOK: begin
        if (!key_ok) begin
          // key past the table: dropped, nothing touched
          res_valid_d = 1'b1;
        end else if (mode_q == MODE_FREQUENCY) begin
          ram_we      = 1'b1;
          ram_wdata   = {(cnt_hit ? CNT_W'(0) : cur_cnt + CNT_W'(1)), cur_win};
          res_valid_d = 1'b1;
          res_acc_d   = cnt_hit;
        end else if (!time_late) begin
          // still inside the window; a fresh key is stored anyway
          ram_we      = 1'b1;
          res_valid_d = 1'b1;
        end else if (zero_len) begin
          ram_we      = 1'b1;
          ram_wdata   = {cur_cnt, time_q};
          res_valid_d = 1'b1;
          res_acc_d   = 1'b1;
        end else begin
          mod_start = 1'b1;
        end
      end
      ST_FIN: begin
        ram_we      = 1'b1;
        ram_wdata   = {cnt_q, new_win};
        res_valid_d = 1'b1;
        res_acc_d   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      res_valid_q <= 1'b0;
      res_acc_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      res_acc_q   <= res_acc_d;
      if (ram_we) begin
        seen_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q  <= stream_key_i;
      addr_q <= AW'(stream_key_i);
      time_q <= sample_time_i;
    end
    if (state_q == ST_LOOK) begin
      cnt_q <= cur_cnt;
    end
  end

  assign result_valid_o = res_valid_q;
  assign accepted_o     = res_acc_q;

endmodule

>>> design/keyed_record_thinning_chk.sv
// ----------------------------------------------------------------------------
// keyed_record_thinning_chk
// Port-level checks on the record/result sequencing of the thinning filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keyed_record_thinning_assert.svh"

module keyed_record_thinning_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic accepted_o
);

  // A taken record always makes the block busy in the cycle after
  `KRT_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // A result only appears as the block returns to idle
  `KRT_ASSERT(a_res_idle, clk_i, rst_ni, !result_valid_o || (!busy_o && $past(busy_o)))
  // Every finished record yields its result
  `KRT_ASSERT(a_fell_res, clk_i, rst_ni, !$fell(busy_o) || result_valid_o)
  // One result per record: the strobe is never high back to back
  `KRT_ASSERT_NEXT(a_res_pulse, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // An accept flag is only meaningful with its strobe
  `KRT_ASSERT(a_acc_strobe, clk_i, rst_ni, !accepted_o || result_valid_o)

endmodule

bind keyed_record_thinning keyed_record_thinning_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .accepted_o     (accepted_o)
);

>>> dv/tb_keyed_record_thinning.sv
// ----------------------------------------------------------------------------
// tb_keyed_record_thinning
// Self-checking bench for the per-key thinning filter. A directed table walks
// the reset state, field extremes, both modes, zero intervals and window
// saturation. Randomized phases follow, each with its own register setting.
// Each result is checked against its typed-in flag or an in-bench model of the key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_record_thinning;
  import krt_pkg::*;

  localparam int unsigned N_KEYS         = 16;
  localparam int unsigned T_W            = 48;
  localparam logic [T_W-1:0] T_MAX       = '1;
  localparam int unsigned RAND_RECORDS   = 550;
  localparam int unsigned MAX_REPORTS    = 10;
  // Drain margin, longer than the longest record (an accepted time-mode divide).
  localparam int unsigned DRAIN_CYCLES   = 64;
  // Cycles with no request, result or register write before giving up.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [KEY_W-1:0]      stream_key_i;
  logic [T_W-1:0]        sample_time_i;
  logic                  result_valid_o;
  logic                  accepted_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  keyed_record_thinning #(
    .NUM_KEYS  (N_KEYS),
    .TIME_WIDTH(T_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .stream_key_i  (stream_key_i),
    .sample_time_i (sample_time_i),
    .result_valid_o(result_valid_o),
    .accepted_o    (accepted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 20 ns period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Key table model: mirrors the filter's per-key state and its registers.
  // --------------------------------------------------------------------------
  logic           key_seen_m  [N_KEYS];
  logic [15:0]    rec_count_m [N_KEYS];
  logic [T_W-1:0] win_start_m [N_KEYS];
  logic           mode_m;
  logic [15:0]    interval_m;
  logic [T_W-1:0] origin_m;

  // Expected accept flags, oldest first
  logic accept_due_q[$];

  int unsigned n_records;
  int unsigned n_time_records;
  int unsigned n_passed;
  int unsigned n_reg_writes;
  int unsigned n_mismatch;
  int unsigned stall_cycles;
  bit          no_idle;

  // Judge one record and update the table the same way the filter must.
  function automatic logic judge_record(logic [KEY_W-1:0] key, logic [T_W-1:0] stamp);
    logic [63:0] win_len;
    logic [63:0] step;
    if (!key_seen_m[key]) begin
      key_seen_m[key]  = 1'b1;
      rec_count_m[key] = '0;
      win_start_m[key] = origin_m;
    end
    if (mode_m == MODE_FREQUENCY) begin
      // target wraps to 65535 when the interval is zero
      if (rec_count_m[key] == 16'(interval_m - 16'd1)) begin
        rec_count_m[key] = '0;
        return 1'b1;
      end
      rec_count_m[key] = rec_count_m[key] + 16'd1;
      return 1'b0;
    end
    if (stamp <= win_start_m[key]) return 1'b0;
    win_len = 64'(interval_m) << TICK_SHIFT;
    if (win_len == 64'd0) begin
      win_start_m[key] = stamp;
      return 1'b1;
    end
    // jump to the first boundary strictly past the record
    step = win_len - ((64'(stamp) - 64'(win_start_m[key])) % win_len);
    if (step > 64'(T_MAX) - 64'(stamp)) win_start_m[key] = T_MAX;
    else win_start_m[key] = T_W'(64'(stamp) + step);
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // One record request. Idles first at random, then holds start until taken.
  task automatic send_record(input logic [KEY_W-1:0] key, input logic [T_W-1:0] stamp,
                             input bit fixed, input logic fixed_acc);
    logic predicted;
    cfg_valid_i <= 1'b0;
    if (!no_idle && $urandom_range(99) < 17) begin
      start_i <= 1'b0;
      // mostly short gaps, now and then one that outlasts a long divide
      if ($urandom_range(9) == 0) repeat ($urandom_range(9, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    stream_key_i  <= key;
    sample_time_i <= stamp;
    do @(posedge clk_i); while (busy_o);
    predicted = judge_record(key, stamp);
    accept_due_q = {accept_due_q, (fixed ? fixed_acc : predicted)};
    n_records++;
    if (mode_m == MODE_TIME) n_time_records++;
  endtask

  // Register write, only once the filter has drained.
  task automatic write_reg(input krt_cfg_e sel, input logic [CFG_DATA_W-1:0] data);
    start_i <= 1'b0;
    if (accept_due_q.size() != 0 || (!no_idle && $urandom_range(99) < 17)) begin
      cfg_valid_i <= 1'b0;
      while (accept_due_q.size() != 0) @(posedge clk_i);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      CFG_THIN_MODE:     mode_m     = data[0];
      CFG_THIN_INTERVAL: interval_m = data[15:0];
      CFG_WINDOW_ORIGIN: origin_m   = T_W'(data);
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every strobe is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && result_valid_o) begin
      if (accept_due_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending, accepted=%0b", accepted_o));
      end else begin
        want = accept_due_q.pop_front();
        if (accepted_o !== want)
          note_mismatch($sformatf("accepted expected %0b got %0b", want, accepted_o));
        if (accepted_o === 1'b1) n_passed++;
      end
    end
  end

  // Watchdog on progress of any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, stall_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit               is_write;
    krt_cfg_e         reg_sel;
    logic [47:0]      reg_data;
    logic [KEY_W-1:0] key;
    logic [T_W-1:0]   stamp;
    bit               fixed;      // expected flag typed in below
    logic             fixed_acc;
  } step_t;

  step_t plan_q[$];

  function automatic void plan_write(krt_cfg_e sel, logic [47:0] data);
    step_t s;
    s          = '{reg_sel: CFG_THIN_MODE, default: '0};
    s.is_write = 1'b1;
    s.reg_sel  = sel;
    s.reg_data = data;
    plan_q     = {plan_q, s};
  endfunction

  function automatic void plan_rec(logic [KEY_W-1:0] key, logic [T_W-1:0] stamp,
                                   bit fixed, logic fixed_acc);
    step_t s;
    s           = '{reg_sel: CFG_THIN_MODE, default: '0};
    s.key       = key;
    s.stamp     = stamp;
    s.fixed     = fixed;
    s.fixed_acc = fixed_acc;
    plan_q      = {plan_q, s};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      phase;
    int unsigned      phase_len;
    int unsigned      roll;
    int unsigned      n_rand;
    logic [KEY_W-1:0] k;
    logic [T_W-1:0]   t;
    logic [T_W-1:0]   base;
    logic [63:0]      win_len;
    longint           aim;
    logic             p_mode;
    logic [15:0]      p_intv;
    logic [T_W-1:0]   p_orig;

    rst_ni        = 1'b0;
    start_i       = 1'b0;
    stream_key_i  = '0;
    sample_time_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_THIN_MODE;
    cfg_wdata_i   = '0;
    stall_cycles  = 0;
    n_records     = 0;
    n_time_records = 0;
    n_passed      = 0;
    n_reg_writes  = 0;
    n_mismatch    = 0;
    no_idle       = 1'b0;
    n_rand        = 0;
    mode_m        = MODE_FREQUENCY;
    interval_m    = 16'd1;
    origin_m      = '0;
    for (int i = 0; i < N_KEYS; i++) begin
      key_seen_m[i]  = 1'b0;
      rec_count_m[i] = '0;
      win_start_m[i] = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: count mode, every record passes
    plan_rec(4'd0,  '0,    1, 1'b1);
    plan_rec(4'd15, T_MAX, 1, 1'b1);
    // every third record of a key
    plan_write(CFG_THIN_INTERVAL, 48'd3);
    plan_rec(4'd1, 48'd5, 1, 1'b0);
    plan_rec(4'd1, 48'd5, 1, 1'b0);
    plan_rec(4'd1, 48'd5, 1, 1'b1);
    // zero interval in count mode: one in 65536
    plan_write(CFG_THIN_INTERVAL, 48'd0);
    plan_rec(4'd2, 48'h5555_5555_5555, 1, 1'b0);
    plan_rec(4'd2, 48'hAAAA_AAAA_AAAA, 0, 1'b0);
    // time mode, one-second windows from zero
    plan_write(CFG_THIN_MODE, 48'(MODE_TIME));
    plan_write(CFG_THIN_INTERVAL, 48'd1);
    plan_write(CFG_WINDOW_ORIGIN, 48'd0);
    plan_rec(4'd3, 48'd0,    1, 1'b0);   // not past the start
    plan_rec(4'd3, 48'd1,    1, 1'b1);   // window moves to 1024
    plan_rec(4'd3, 48'd1024, 1, 1'b0);   // on the boundary
    plan_rec(4'd3, 48'd1025, 1, 1'b1);
    // window start pinned at the top of the time range
    plan_rec(4'd5, T_MAX, 1, 1'b1);
    plan_rec(4'd5, T_MAX, 1, 1'b0);
    // new key starting at the largest origin
    plan_write(CFG_WINDOW_ORIGIN, 48'(T_MAX));
    plan_rec(4'd4, T_MAX, 1, 1'b0);
    // zero-length windows
    plan_write(CFG_WINDOW_ORIGIN, 48'd0);
    plan_write(CFG_THIN_INTERVAL, 48'd0);
    plan_rec(4'd6, 48'd100, 1, 1'b1);
    plan_rec(4'd6, 48'd100, 1, 1'b0);
    plan_rec(4'd6, 48'd101, 1, 1'b1);
    // longest windows
    plan_write(CFG_THIN_INTERVAL, 48'd65535);
    plan_rec(4'd7, 48'h0000_1234_5678, 0, 1'b0);
    plan_rec(4'd7, 48'hAAAA_5555_AAAA, 0, 1'b0);
    plan_rec(4'd0, 48'h0000_0000_0400, 0, 1'b0);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) write_reg(plan_q[i].reg_sel, plan_q[i].reg_data);
      else send_record(plan_q[i].key, plan_q[i].stamp, plan_q[i].fixed, plan_q[i].fixed_acc);
    end

    // Random phases. The first few pin corner settings, the rest draw freely.
    phase = 0;
    while (n_rand < RAND_RECORDS) begin
      case (phase)
        0: begin p_mode = MODE_FREQUENCY; p_intv = 16'd2;     p_orig = '0;    end
        1: begin p_mode = MODE_TIME;      p_intv = 16'd1;     p_orig = '0;    end
        2: begin p_mode = MODE_TIME;      p_intv = 16'd65535; p_orig = T_MAX; end
        3: begin p_mode = MODE_FREQUENCY; p_intv = 16'd65535; p_orig = T_W'(48'd77); end
        default: begin
          p_mode = logic'($urandom_range(1));
          roll   = $urandom_range(9);
          if (roll == 0)      p_intv = 16'd0;
          else if (roll == 1) p_intv = 16'd1;
          else if (roll == 2) p_intv = 16'd65535;
          else if (roll < 8)  p_intv = 16'($urandom_range(2, 8));
          else                p_intv = 16'($urandom_range(9, 65534));
          roll = $urandom_range(3);
          if (roll == 0)      p_orig = '0;
          else if (roll == 1) p_orig = T_MAX;
          else if (roll == 2) p_orig = T_W'({$urandom(), $urandom()});
          else                p_orig = T_W'($urandom_range(0, 100000));
        end
      endcase
      // phase 4 runs back to back with no idle cycles
      no_idle = (phase == 4);
      write_reg(CFG_THIN_MODE, 48'(p_mode));
      write_reg(CFG_THIN_INTERVAL, 48'(p_intv));
      write_reg(CFG_WINDOW_ORIGIN, 48'(p_orig));

      phase_len = $urandom_range(40, 70);
      for (int n = 0; n < phase_len && n_rand < RAND_RECORDS; n++) begin
        if (mode_m == MODE_FREQUENCY) begin
          // few keys so counts actually reach the interval
          k = ($urandom_range(9) < 7) ? KEY_W'($urandom_range(3)) : KEY_W'($urandom_range(15));
          t = T_W'({$urandom(), $urandom()});
        end else begin
          k       = ($urandom_range(1) == 0) ? KEY_W'($urandom_range(3))
                                             : KEY_W'($urandom_range(15));
          base    = key_seen_m[k] ? win_start_m[k] : origin_m;
          win_len = 64'(interval_m) << TICK_SHIFT;
          roll    = $urandom_range(99);
          if (roll < 60) begin
            // land around the current window start: before, on, a few windows past
            aim = longint'(base) + longint'($urandom_range(0, 32'(3 * win_len + 4)))
                  - longint'(win_len / 2);
            if (aim < 0) t = '0;
            else if (aim > longint'(T_MAX)) t = T_MAX;
            else t = T_W'(aim);
          end else if (roll < 75) begin
            t = base;
          end else if (roll < 88) begin
            t = T_W'({$urandom(), $urandom()});
          end else begin
            t = T_MAX - T_W'($urandom_range(0, 4096));
          end
        end
        send_record(k, t, 1'b0, 1'b0);
        n_rand++;
      end
      phase++;
    end

    // drain
    start_i     <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (accept_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (accept_due_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", accept_due_q.size()));

    $display("Run covered %0d records (%0d in time mode) over %0d random phases.",
             n_records, n_time_records, phase);
    $display("%0d records passed thinning, %0d register writes, %0d mismatches.",
             n_passed, n_reg_writes, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/krt_pkg.sv
design/krt_ram.sv
design/krt_mod.sv
design/keyed_record_thinning.sv
design/keyed_record_thinning_chk.sv
dv/tb_keyed_record_thinning.sv
